>>> hdl/pst_pkg.sv
// ----------------------------------------------------------------------------
// pst_pkg
// Shared types, constants and the control store of the prime sieve table.
// ----------------------------------------------------------------------------
package pst_pkg;

    localparam int unsigned MAX_N_DEF = 1024;
    localparam int unsigned LIM_W     = 11;
    localparam int unsigned VAL_W     = 12;   // counters: top + base stays below 4096
    localparam logic [LIM_W-1:0] LIMIT_RST = 11'd100;

    localparam logic ACT_SIEVE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // datapath operations
    localparam logic [3:0] OP_NOP       = 4'd0;
    localparam logic [3:0] OP_ACCEPT    = 4'd1;
    localparam logic [3:0] OP_SETUP     = 4'd2;
    localparam logic [3:0] OP_FILL      = 4'd3;
    localparam logic [3:0] OP_B_INIT    = 4'd4;
    localparam logic [3:0] OP_READ_B    = 4'd5;
    localparam logic [3:0] OP_M_INIT    = 4'd6;
    localparam logic [3:0] OP_MARK      = 4'd7;
    localparam logic [3:0] OP_B_INC     = 4'd8;
    localparam logic [3:0] OP_RES_SIEVE = 4'd9;
    localparam logic [3:0] OP_READ_NUM  = 4'd10;
    localparam logic [3:0] OP_RES_QUERY = 4'd11;

    // jump conditions
    localparam logic [3:0] C_NEVER     = 4'd0;
    localparam logic [3:0] C_ALWAYS    = 4'd1;
    localparam logic [3:0] C_NO_FIRE   = 4'd2;
    localparam logic [3:0] C_QUERY     = 4'd3;
    localparam logic [3:0] C_K_LT_TOP  = 4'd4;
    localparam logic [3:0] C_SQ_GT_TOP = 4'd5;
    localparam logic [3:0] C_FLAG_ZERO = 4'd6;
    localparam logic [3:0] C_M_LE_TOP  = 4'd7;
    localparam logic [3:0] C_OUT_FREE  = 4'd8;

    // step addresses
    localparam logic [3:0] UA_IDLE  = 4'd0;
    localparam logic [3:0] UA_DISP  = 4'd1;
    localparam logic [3:0] UA_SETUP = 4'd2;
    localparam logic [3:0] UA_FILL  = 4'd3;
    localparam logic [3:0] UA_BINIT = 4'd4;
    localparam logic [3:0] UA_BTEST = 4'd5;
    localparam logic [3:0] UA_BCHK  = 4'd6;
    localparam logic [3:0] UA_MARK  = 4'd7;
    localparam logic [3:0] UA_BNEXT = 4'd8;
    localparam logic [3:0] UA_DONE  = 4'd9;
    localparam logic [3:0] UA_QRD   = 4'd10;
    localparam logic [3:0] UA_QRES  = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] cond;
        logic       hold;     // stay on this step while cond is false
        logic [3:0] target;
    } ucode_t;

    typedef struct packed {
        logic fire;
        logic query;
        logic k_lt_top;
        logic sq_gt_top;
        logic flag_zero;
        logic m_le_top;
        logic out_free;
    } seq_status_t;

    function automatic ucode_t ucode_rom(input logic [3:0] addr);
        ucode_t w;
        w = '{op: OP_NOP, cond: C_ALWAYS, hold: 1'b0, target: UA_IDLE};
        case (addr)
            UA_IDLE:  w = '{op: OP_ACCEPT,    cond: C_NO_FIRE,   hold: 1'b0, target: UA_IDLE};
            UA_DISP:  w = '{op: OP_NOP,       cond: C_QUERY,     hold: 1'b0, target: UA_QRD};
            UA_SETUP: w = '{op: OP_SETUP,     cond: C_NEVER,     hold: 1'b0, target: UA_IDLE};
            UA_FILL:  w = '{op: OP_FILL,      cond: C_K_LT_TOP,  hold: 1'b0, target: UA_FILL};
            UA_BINIT: w = '{op: OP_B_INIT,    cond: C_NEVER,     hold: 1'b0, target: UA_IDLE};
            UA_BTEST: w = '{op: OP_READ_B,    cond: C_SQ_GT_TOP, hold: 1'b0, target: UA_DONE};
            UA_BCHK:  w = '{op: OP_M_INIT,    cond: C_FLAG_ZERO, hold: 1'b0, target: UA_BNEXT};
            UA_MARK:  w = '{op: OP_MARK,      cond: C_M_LE_TOP,  hold: 1'b0, target: UA_MARK};
            UA_BNEXT: w = '{op: OP_B_INC,     cond: C_ALWAYS,    hold: 1'b0, target: UA_BTEST};
            UA_DONE:  w = '{op: OP_RES_SIEVE, cond: C_OUT_FREE,  hold: 1'b1, target: UA_IDLE};
            UA_QRD:   w = '{op: OP_READ_NUM,  cond: C_NEVER,     hold: 1'b0, target: UA_IDLE};
            UA_QRES:  w = '{op: OP_RES_QUERY, cond: C_OUT_FREE,  hold: 1'b1, target: UA_IDLE};
            default:  w = '{op: OP_NOP,       cond: C_ALWAYS,    hold: 1'b0, target: UA_IDLE};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/pst_ram.sv
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module pst_ram #(
    parameter int unsigned WIDTH = 1,
    parameter int unsigned DEPTH = 1025
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/pst_seq.sv
// ----------------------------------------------------------------------------
// pst_seq
// Step counter and control store; selects the next step from status flags.
// ----------------------------------------------------------------------------
module pst_seq
    import pst_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  seq_status_t status,
    output ucode_t      word
);

    logic [3:0] upc_reg;
    logic [3:0] upc_next;
    logic       cond_true;

    assign word = ucode_rom(upc_reg);

    always_comb
    begin
        case (word.cond)
            C_NEVER:     cond_true = 1'b0;
            C_ALWAYS:    cond_true = 1'b1;
            C_NO_FIRE:   cond_true = !status.fire;
            C_QUERY:     cond_true = status.query;
            C_K_LT_TOP:  cond_true = status.k_lt_top;
            C_SQ_GT_TOP: cond_true = status.sq_gt_top;
            C_FLAG_ZERO: cond_true = status.flag_zero;
            C_M_LE_TOP:  cond_true = status.m_le_top;
            C_OUT_FREE:  cond_true = status.out_free;
            default:     cond_true = 1'b1;
        endcase
    end

    always_comb
    begin
        if (cond_true)
        begin
            upc_next = word.target;
        end
        else if (word.hold)
        begin
            upc_next = upc_reg;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= UA_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

>>> hdl/prime_sieve_table.sv
// ----------------------------------------------------------------------------
// prime_sieve_table
// Sieve of Eratosthenes over 2..limit with a one-bit flag per number.
// ----------------------------------------------------------------------------
// Input items: tuser = action (0 sieve, 1 query), tdata = number.
// Every item gives one result item: tdata bit 0 is_prime, bit 1 in_range.
// limit is written through cfg_wr_en / cfg_wr_data; the user must do so only
// while the block is idle (not enforced by the block); it saturates at MAX_N.
// A query passes from acceptance through the dispatch step, the flag RAM read
// and the result step to a valid result; input is accepted only on the idle
// step, so no new item is taken before the last has left its result step.
// A sieve writes one flag per step in the fill and marking loops of the
// sequencer, with three steps per base and one more for each prime base.
// The result sits in an output register; the next item is accepted while it
// waits. A stalled receiver holds the sequencer on its result step.
// Reset sets limit to 100 and marks no number prime; the flag RAM is not
// cleared, a sieved-range register masks entries that were never written.
// ----------------------------------------------------------------------------
module prime_sieve_table
    import pst_pkg::*;
#(
    parameter int unsigned MAX_N = MAX_N_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [10:0] cfg_wr_data,    // limit
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [10:0] number, rest zero
    input  logic        s_axis_tuser,   // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] is_prime, [1] in_range, rest zero
);

    localparam int unsigned DEPTH = MAX_N + 1;
    localparam int unsigned AW    = $clog2(DEPTH);

    ucode_t      word;
    seq_status_t status;

    logic [LIM_W-1:0] limit_reg;
    logic [LIM_W-1:0] eff_limit;
    logic             act_reg;
    logic [LIM_W-1:0] num_reg;
    logic [VAL_W-1:0] top_reg;
    logic [VAL_W-1:0] k_reg;
    logic [VAL_W-1:0] b_reg;
    logic [VAL_W-1:0] m_reg;
    logic [2*VAL_W-1:0] b_sq;

    logic             out_valid_reg;
    logic             is_prime_reg;
    logic             in_range_reg;

    logic             fire;
    logic             out_free;
    logic             m_le_top;
    logic             q_in_range;
    logic             q_is_prime;
    logic             res_load;

    logic             ram_we;
    logic [AW-1:0]    ram_wr_addr;
    logic             ram_wr_data;
    logic             ram_rd_en;
    logic [AW-1:0]    ram_rd_addr;
    logic             ram_rd_data;

    pst_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .word   (word)
    );

    pst_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_flags (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign eff_limit = (32'(limit_reg) > 32'(MAX_N)) ? LIM_W'(MAX_N) : limit_reg;

    assign s_axis_tready = (word.op == OP_ACCEPT);
    assign fire          = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign b_sq          = b_reg * b_reg;
    assign m_le_top      = (m_reg <= top_reg);

    assign status.fire      = fire;
    assign status.query     = (act_reg == ACT_QUERY);
    assign status.k_lt_top  = (k_reg < top_reg);
    assign status.sq_gt_top = (b_sq > {{VAL_W{1'b0}}, top_reg});
    assign status.flag_zero = !ram_rd_data;
    assign status.m_le_top  = m_le_top;
    assign status.out_free  = out_free;

    assign ram_we      = (word.op == OP_FILL) || ((word.op == OP_MARK) && m_le_top);
    assign ram_wr_addr = (word.op == OP_FILL) ? AW'(k_reg) : AW'(m_reg);
    assign ram_wr_data = (word.op == OP_FILL);
    assign ram_rd_en   = (word.op == OP_READ_B) || (word.op == OP_READ_NUM);
    assign ram_rd_addr = (word.op == OP_READ_NUM) ? AW'(num_reg) : AW'(b_reg);

    // entries above the last sieved top hold no result of that sieve
    assign q_in_range = (num_reg >= LIM_W'(2)) && (num_reg <= eff_limit);
    assign q_is_prime = q_in_range && ({1'b0, num_reg} <= top_reg) && ram_rd_data;

    assign res_load = out_free
                      && ((word.op == OP_RES_SIEVE) || (word.op == OP_RES_QUERY));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_RST;
            top_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (word.op == OP_SETUP)
            begin
                top_reg <= VAL_W'(eff_limit);
            end
            if (res_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            act_reg <= s_axis_tuser;
            num_reg <= s_axis_tdata[LIM_W-1:0];
        end
        case (word.op)
            OP_SETUP:  k_reg <= VAL_W'(2);
            OP_FILL:   k_reg <= k_reg + VAL_W'(1);
            OP_B_INIT: b_reg <= VAL_W'(2);
            OP_B_INC:  b_reg <= b_reg + VAL_W'(1);
            OP_M_INIT: m_reg <= b_reg + b_reg;
            OP_MARK:   m_reg <= m_reg + b_reg;
            default:   ;
        endcase
        if (res_load)
        begin
            is_prime_reg <= (word.op == OP_RES_QUERY) && q_is_prime;
            in_range_reg <= (word.op == OP_RES_SIEVE) || q_in_range;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, in_range_reg, is_prime_reg};

    a_prime_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("is_prime set without in_range");

    a_mark_above_base: assert property (@(posedge clk) disable iff (!rst_n)
        (word.op == OP_MARK) |-> (m_reg >= (b_reg + b_reg)))
        else $error("marking below twice the base");

    a_no_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !ram_we)
        else $error("flag write while accepting items");

    a_fill_from_two: assert property (@(posedge clk) disable iff (!rst_n)
        (word.op == OP_FILL) |-> (k_reg >= VAL_W'(2)))
        else $error("fill below two");

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for the prime sieve table.
// A table of directed items covers the reset state, the range extremes,
// saturation of the limit, limits below two and a limit change without a new
// sieve. Random phases follow. Each phase writes a new limit, then mostly sends
// a sieve and a run of queries with rare sieves among them. Every result item
// is checked against the answer given in its row or a local sieve predictor.
// Both stream sides idle at random, with one phase of back-to-back traffic.
// ----------------------------------------------------------------------------
module tb;
    import pst_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 40000;
    localparam int unsigned RANDOM_ITEMS = 1300;
    localparam int unsigned N_ROWS = 34;

    typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic        action;
        logic [10:0] arg;       // number, or the limit for ROW_LIMIT
        logic        typed;     // expected answer given in the row
        logic        exp_prime;
        logic        exp_inr;
    } stim_row_t;

    typedef struct packed {
        logic is_prime;
        logic in_range;
    } answer_t;

    localparam stim_row_t DIRECTED_ROWS [0:N_ROWS-1] = '{
        '{ROW_ITEM,  ACT_QUERY, 11'd2,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd0,    1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd2047, 1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd2047, 1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd97,   1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd100,  1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd101,  1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1,    1'b1, 1'b0, 1'b0},
        '{ROW_LIMIT, ACT_SIEVE, 11'd1024, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1021, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd1024, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1021, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1025, 1'b1, 1'b0, 1'b0},
        '{ROW_LIMIT, ACT_SIEVE, 11'd2047, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1024, 1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1025, 1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd1019, 1'b0, 1'b0, 1'b0},
        '{ROW_LIMIT, ACT_SIEVE, 11'd1,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd2,    1'b1, 1'b0, 1'b0},
        '{ROW_LIMIT, ACT_SIEVE, 11'd0,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd0,    1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd1,    1'b1, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_LIMIT, ACT_SIEVE, 11'd2,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd2,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd3,    1'b1, 1'b0, 1'b0},
        '{ROW_LIMIT, ACT_SIEVE, 11'd4,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_SIEVE, 11'd0,    1'b1, 1'b0, 1'b1},
        '{ROW_ITEM,  ACT_QUERY, 11'd4,    1'b0, 1'b0, 1'b0},
        '{ROW_ITEM,  ACT_QUERY, 11'd3,    1'b0, 1'b0, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [10:0] cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [10:0] number
    logic        s_axis_tuser = 1'b0;   // action
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [0] is_prime, [1] in_range

    logic        steady = 1'b0;
    int unsigned err_count = 0;

    // predictor state
    bit          sieve_flags [0:MAX_N_DEF];
    logic [10:0] sieve_limit = LIMIT_RST;
    answer_t     pending_answers [$];

    prime_sieve_table u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int unsigned active_top();
        if (sieve_limit > MAX_N_DEF)
            return MAX_N_DEF;
        return 32'(sieve_limit);
    endfunction

    function automatic void rebuild_flags();
        int unsigned top;
        int unsigned b;
        int unsigned m;
        top = active_top();
        for (int unsigned k = 0; k <= MAX_N_DEF; k++)
            sieve_flags[k] = (k >= 2) && (k <= top);
        for (b = 2; b * b <= top; b++)
        begin
            if (sieve_flags[b])
            begin
                for (m = 2 * b; m <= top; m += b)
                    sieve_flags[m] = 1'b0;
            end
        end
    endfunction

    function automatic answer_t sieve_response(input logic act, input logic [10:0] num);
        answer_t ans;
        int unsigned top;
        if (act == ACT_SIEVE)
        begin
            rebuild_flags();
            ans.is_prime = 1'b0;
            ans.in_range = 1'b1;
        end
        else
        begin
            top = active_top();
            ans.in_range = (num >= 2) && (num <= top);
            ans.is_prime = ans.in_range ? sieve_flags[num] : 1'b0;
        end
        return ans;
    endfunction

    task automatic send_item(input logic act, input logic [10:0] num,
                             input logic use_typed, input answer_t typed_ans);
        answer_t ans;
        @(negedge clk);
        while (!steady && $urandom_range(99, 0) < 38)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {5'b0, num};
        do
            @(posedge clk);
        while (!s_axis_tready);
        ans = sieve_response(act, num);
        pending_answers.push_back(use_typed ? typed_ans : ans);
    endtask

    task automatic send_random(input logic act, input logic [10:0] num);
        send_item(act, num, 1'b0, '0);
    endtask

    task automatic write_limit(input logic [10:0] value);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        sieve_limit = value;
    endtask

    function automatic logic [10:0] pick_limit();
        int unsigned r;
        r = $urandom_range(99, 0);
        if (r < 50)
            return 11'($urandom_range(150, 2));
        if (r < 75)
            return 11'($urandom_range(1024, 151));
        case ($urandom_range(6, 0))
            0:       return 11'd0;
            1:       return 11'd1;
            2:       return 11'd2;
            3:       return 11'd3;
            4:       return 11'd1024;
            5:       return 11'd2047;
            default: return 11'($urandom_range(2047, 1025));
        endcase
    endfunction

    function automatic logic [10:0] pick_number();
        int unsigned hi;
        hi = active_top() + 3;
        if ($urandom_range(99, 0) < 80)
            return 11'($urandom_range(hi, 0));
        return 11'($urandom_range(2047, 0));
    endfunction

    always @(negedge clk)
        m_axis_tready <= steady || ($urandom_range(99, 0) >= 38);

    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("result item with no expectation: tdata %h", m_axis_tdata);
                err_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tdata[0] !== want.is_prime)
                begin
                    $error("is_prime: expected %0b, actual %0b", want.is_prime, m_axis_tdata[0]);
                    err_count++;
                end
                if (m_axis_tdata[1] !== want.in_range)
                begin
                    $error("in_range: expected %0b, actual %0b", want.in_range, m_axis_tdata[1]);
                    err_count++;
                end
            end
        end
    end

    initial
    begin : watchdog
        int unsigned stalled;
        stalled = 0;
        while (stalled < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || cfg_wr_en || !rst_n)
                stalled = 0;
            else
                stalled++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin : stimulus
        stim_row_t   row;
        answer_t     typed_ans;
        int unsigned sent;
        int unsigned phase;
        int unsigned run_len;
        rebuild_flags();
        for (int unsigned k = 0; k <= MAX_N_DEF; k++)
            sieve_flags[k] = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int unsigned i = 0; i < N_ROWS; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (row.kind == ROW_LIMIT)
                write_limit(row.arg);
            else
            begin
                typed_ans.is_prime = row.exp_prime;
                typed_ans.in_range = row.exp_inr;
                send_item(row.action, row.arg, row.typed, typed_ans);
            end
        end

        sent = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            write_limit(pick_limit());
            steady = (phase == 3);
            if ($urandom_range(99, 0) < 75)
            begin
                send_random(ACT_SIEVE, 11'($urandom_range(2047, 0)));
                sent++;
            end
            run_len = $urandom_range(120, 40);
            for (int unsigned j = 0; j < run_len; j++)
            begin
                if ($urandom_range(99, 0) < 3)
                    send_random(ACT_SIEVE, 11'($urandom_range(2047, 0)));
                else
                    send_random(ACT_QUERY, pick_number());
                sent++;
            end
            steady = 1'b0;
            phase++;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
